@@ rtl/core/dils_pkg.sv @@
// ----------------------------------------------------------------------------
// dils_pkg: display init list sequencer package
// Result kinds, list walker phases and the fixed constants of the list format.
// ----------------------------------------------------------------------------
package dils_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned CountW = 7;
	localparam int unsigned MsW    = 15;

	localparam logic [ByteW-1:0] EndMark   = 8'h00;
	localparam logic [ByteW-1:0] NoCmdMark = 8'hFF;
	localparam int unsigned      DelayBit  = 7;

	localparam logic [ByteW-1:0] UnitReset = 8'd5;

	typedef enum logic [1:0] {
		KIND_CMD   = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_DELAY = 2'd2,
		KIND_END   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_CMD   = 2'd0,
		PH_COUNT = 2'd1,
		PH_DATA  = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

endpackage

@@ rtl/core/dils_if.sv @@
// ----------------------------------------------------------------------------
// dils_if: stream interfaces of the display init list sequencer
// Valid/ready channels for list bytes in and sequencer requests out.
// ----------------------------------------------------------------------------
interface dils_byte_if;
	logic                        valid;
	logic                        ready;
	logic [dils_pkg::ByteW-1:0]  list_byte;

	modport source (output valid, output list_byte, input ready);
	modport sink   (input valid, input list_byte, output ready);
endinterface

interface dils_req_if;
	logic                        valid;
	logic                        ready;
	dils_pkg::kind_t             kind;
	logic [dils_pkg::ByteW-1:0]  byte_value;
	logic [dils_pkg::MsW-1:0]    delay_ms;

	modport source (output valid, output kind, output byte_value, output delay_ms,
		input ready);
	modport sink   (input valid, input kind, input byte_value, input delay_ms,
		output ready);
endinterface

@@ rtl/core/display_init_list_sequencer.sv @@
// ----------------------------------------------------------------------------
// display_init_list_sequencer: packed display init list walker
// Turns a byte stream of command/count/data entries into command, data,
// delay and end-of-list requests.
// ----------------------------------------------------------------------------
//
//   channel    dir   handshake      payload
//   list_in    in    valid/ready    list_byte[7:0]
//   req_out    out   valid/ready    kind[1:0], byte_value[7:0], delay_ms[14:0]
//   cfg        in    cfg_we         cfg_wdata[7:0] -> delay unit in ms
//
// one byte per cycle; a byte's request sits in the output register in the
// cycle after its transfer, set by a single 7x8 multiply and the phase logic
// list_in.ready stays high unless a request is held by a stalled sink
// arst_n returns to the command phase, delay unit 5 ms, no request pending
// after the end marker every byte is taken and dropped until reset
//
module display_init_list_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	dils_byte_if.sink                   list_in,
	dils_req_if.source                  req_out,
	input  logic                        cfg_we,
	input  logic [dils_pkg::ByteW-1:0]  cfg_wdata
);

	// walker state
	dils_pkg::phase_t                phase_q, phase_d;
	logic [dils_pkg::CountW-1:0]     args_left_q, args_left_d;
	logic [dils_pkg::ByteW-1:0]      unit_q;

	// output register
	logic                            valid_s1;
	dils_pkg::kind_t                 kind_s1;
	logic [dils_pkg::ByteW-1:0]      byte_s1;
	logic [dils_pkg::MsW-1:0]        ms_s1;

	// request computed from the byte being transferred
	logic                            res_valid;
	dils_pkg::kind_t                 res_kind;
	logic [dils_pkg::ByteW-1:0]      res_byte;
	logic [dils_pkg::MsW-1:0]        res_ms;

	logic                            accept;
	logic [dils_pkg::ByteW-1:0]      b;
	logic [dils_pkg::CountW-1:0]     count;
	logic                            delay_flag;

	// free to take a byte whenever the output register empties this cycle
	assign list_in.ready = !valid_s1 || req_out.ready;
	assign accept        = list_in.valid && list_in.ready;

	assign b          = list_in.list_byte;
	assign count      = b[dils_pkg::CountW-1:0];
	assign delay_flag = b[dils_pkg::DelayBit];

	// next phase and data countdown
	always_comb begin
		phase_d     = phase_q;
		args_left_d = args_left_q;
		case (phase_q)
			dils_pkg::PH_CMD: begin
				if (b == dils_pkg::EndMark) phase_d = dils_pkg::PH_DONE;
				else                        phase_d = dils_pkg::PH_COUNT;
			end
			dils_pkg::PH_COUNT: begin
				if (delay_flag || count == '0) begin
					phase_d = dils_pkg::PH_CMD;
				end else begin
					phase_d     = dils_pkg::PH_DATA;
					args_left_d = count;
				end
			end
			dils_pkg::PH_DATA: begin
				args_left_d = args_left_q - 1'b1;
				if (args_left_q == dils_pkg::CountW'(1)) phase_d = dils_pkg::PH_CMD;
			end
			dils_pkg::PH_DONE: begin
				phase_d = dils_pkg::PH_DONE;
			end
			default: begin
				phase_d = dils_pkg::PH_CMD;
			end
		endcase
	end

	// request for the current byte
	always_comb begin
		res_valid = 1'b0;
		res_kind  = dils_pkg::KIND_CMD;
		res_byte  = '0;
		res_ms    = '0;
		case (phase_q)
			dils_pkg::PH_CMD: begin
				if (b == dils_pkg::EndMark) begin
					res_valid = 1'b1;
					res_kind  = dils_pkg::KIND_END;
				end else if (b != dils_pkg::NoCmdMark) begin
					// delay-only entries carry no command byte
					res_valid = 1'b1;
					res_kind  = dils_pkg::KIND_CMD;
					res_byte  = b;
				end
			end
			dils_pkg::PH_COUNT: begin
				if (delay_flag) begin
					res_valid = 1'b1;
					res_kind  = dils_pkg::KIND_DELAY;
					res_ms    = {{(dils_pkg::MsW-dils_pkg::CountW){1'b0}}, count} *
						{{(dils_pkg::MsW-dils_pkg::ByteW){1'b0}}, unit_q};
				end
			end
			dils_pkg::PH_DATA: begin
				res_valid = 1'b1;
				res_kind  = dils_pkg::KIND_DATA;
				res_byte  = b;
			end
			dils_pkg::PH_DONE: begin
				res_valid = 1'b0;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// state and delay unit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= dils_pkg::PH_CMD;
			args_left_q <= '0;
			unit_q      <= dils_pkg::UnitReset;
		end else begin
			if (accept) begin
				phase_q     <= phase_d;
				args_left_q <= args_left_d;
			end
			if (cfg_we) unit_q <= cfg_wdata;
		end
	end

	// output valid: loaded on a transfer in, cleared once the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (list_in.ready) begin
			valid_s1 <= accept && res_valid;
		end
	end

	// output payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			kind_s1 <= res_kind;
			byte_s1 <= res_byte;
			ms_s1   <= res_ms;
		end
	end

	assign req_out.valid      = valid_s1;
	assign req_out.kind       = kind_s1;
	assign req_out.byte_value = byte_s1;
	assign req_out.delay_ms   = ms_s1;

endmodule

@@ rtl/core/dils_checker.sv @@
// ----------------------------------------------------------------------------
// dils_checker: port checks for the display init list sequencer
// Output hold, input readiness, payload zeroing and silence after the end.
// ----------------------------------------------------------------------------
module dils_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_ready,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [1:0]                  out_kind,
	input  logic [dils_pkg::ByteW-1:0]  out_byte,
	input  logic [dils_pkg::MsW-1:0]    out_ms
);

	logic ended_q;

	// set once the end-of-list request has been transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q <= 1'b0;
		end else if (out_valid && out_ready && out_kind == dils_pkg::KIND_END) begin
			ended_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
			$stable(out_byte) && $stable(out_ms))
		else $error("request changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("byte input blocked with no stalled request");

	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == dils_pkg::KIND_DELAY || out_kind == dils_pkg::KIND_END)
			|-> out_byte == '0)
		else $error("nonzero byte on delay or end request");

	a_zero_ms: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != dils_pkg::KIND_DELAY |-> out_ms == '0)
		else $error("nonzero delay on non-delay request");

	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> !out_valid)
		else $error("request after end of list");

endmodule

bind display_init_list_sequencer dils_checker u_dils_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (list_in.ready),
	.out_valid (req_out.valid),
	.out_ready (req_out.ready),
	.out_kind  (req_out.kind),
	.out_byte  (req_out.byte_value),
	.out_ms    (req_out.delay_ms)
);

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench of the display init list sequencer
// Feeds packed init list bytes through the valid/ready input with random gaps
// and receiver stalls. A shadow list walker predicts every command, data,
// delay and end request, and the monitor checks each transfer on the output
// against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb;

	typedef struct packed {
		dils_pkg::kind_t                kind;
		logic [dils_pkg::ByteW-1:0]     byte_value;
		logic [dils_pkg::MsW-1:0]       delay_ms;
	} req_t;

	localparam int HoldCycles = 300;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [dils_pkg::ByteW-1:0]  cfg_wdata;

	dils_byte_if list_if ();
	dils_req_if  req_if ();

	display_init_list_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.list_in   (list_if),
		.req_out   (req_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// bytes waiting to be offered, and predicted requests in order
	logic [dils_pkg::ByteW-1:0] list_q[$];
	req_t                       req_expected[$];

	int unsigned pushed_cnt   = 0;
	int unsigned accepted_cnt = 0;
	int unsigned mismatch_cnt = 0;

	// shadow list walker, advanced at each input transfer
	dils_pkg::phase_t             walk_phase = dils_pkg::PH_CMD;
	logic [dils_pkg::CountW-1:0]  walk_left  = '0;
	logic [dils_pkg::ByteW-1:0]   unit_ms    = dils_pkg::UnitReset;

	// generator's view of where the queued stream stands, so that a zero
	// byte only lands in command position when the list is meant to end
	dils_pkg::phase_t             plan_phase = dils_pkg::PH_CMD;
	logic [dils_pkg::CountW-1:0]  plan_left  = '0;

	// idling controls
	bit          byte_taken = 0;
	int unsigned send_gap   = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left  = 0;
	bit          hold_req   = 0;
	bit          no_idle    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// predict the request, if any, caused by one accepted list byte
	task automatic walk_list_byte(input logic [dils_pkg::ByteW-1:0] b);
		req_t                     r;
		logic [dils_pkg::MsW-1:0] cnt15;
		logic [dils_pkg::MsW-1:0] unit15;
		r      = '{kind: dils_pkg::KIND_CMD, byte_value: '0, delay_ms: '0};
		cnt15  = dils_pkg::MsW'(b[dils_pkg::CountW-1:0]);
		unit15 = dils_pkg::MsW'(unit_ms);
		case (walk_phase)
			dils_pkg::PH_CMD: begin
				if (b == dils_pkg::EndMark) begin
					// end marker: everything after it is dropped
					walk_phase = dils_pkg::PH_DONE;
					r.kind = dils_pkg::KIND_END;
					req_expected.push_back(r);
				end else begin
					walk_phase = dils_pkg::PH_COUNT;
					// delay-only entry sends no command
					if (b != dils_pkg::NoCmdMark) begin
						r.kind = dils_pkg::KIND_CMD;
						r.byte_value = b;
						req_expected.push_back(r);
					end
				end
			end
			dils_pkg::PH_COUNT: begin
				if (b[dils_pkg::DelayBit]) begin
					walk_phase = dils_pkg::PH_CMD;
					r.kind = dils_pkg::KIND_DELAY;
					r.delay_ms = cnt15 * unit15;
					req_expected.push_back(r);
				end else if (b[dils_pkg::CountW-1:0] == '0) begin
					walk_phase = dils_pkg::PH_CMD;
				end else begin
					walk_left  = b[dils_pkg::CountW-1:0];
					walk_phase = dils_pkg::PH_DATA;
				end
			end
			dils_pkg::PH_DATA: begin
				walk_left = walk_left - 1'b1;
				if (walk_left == '0)
					walk_phase = dils_pkg::PH_CMD;
				r.kind = dils_pkg::KIND_DATA;
				r.byte_value = b;
				req_expected.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic queue_byte(input logic [dils_pkg::ByteW-1:0] b);
		list_q.push_back(b);
		pushed_cnt++;
		case (plan_phase)
			dils_pkg::PH_CMD: begin
				plan_phase = (b == dils_pkg::EndMark) ? dils_pkg::PH_DONE
					: dils_pkg::PH_COUNT;
			end
			dils_pkg::PH_COUNT: begin
				if (b[dils_pkg::DelayBit] || b[dils_pkg::CountW-1:0] == '0) begin
					plan_phase = dils_pkg::PH_CMD;
				end else begin
					plan_left  = b[dils_pkg::CountW-1:0];
					plan_phase = dils_pkg::PH_DATA;
				end
			end
			dils_pkg::PH_DATA: begin
				plan_left = plan_left - 1'b1;
				if (plan_left == '0)
					plan_phase = dils_pkg::PH_CMD;
			end
			default: ;
		endcase
	endtask

	// one random byte that never ends the list early
	task automatic queue_noise();
		if (plan_phase == dils_pkg::PH_CMD)
			queue_byte(dils_pkg::ByteW'($urandom_range(1, 255)));
		else
			queue_byte(dils_pkg::ByteW'($urandom_range(0, 255)));
	endtask

	// mostly well-formed entries with random content, some loose bytes
	task automatic queue_entry();
		logic [dils_pkg::ByteW-1:0]  cmd;
		logic [dils_pkg::CountW-1:0] cnt;
		int unsigned                 r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			queue_noise();
		end else begin
			// finish whatever a loose byte left open
			while (plan_phase != dils_pkg::PH_CMD)
				queue_noise();
			cmd = ($urandom_range(0, 4) == 0) ? dils_pkg::NoCmdMark
				: dils_pkg::ByteW'($urandom_range(1, 254));
			queue_byte(cmd);
			if ($urandom_range(0, 9) < 4) begin
				cnt = dils_pkg::CountW'($urandom_range(0, 127));
				queue_byte({1'b1, cnt});
			end else begin
				cnt = ($urandom_range(0, 9) == 0)
					? dils_pkg::CountW'($urandom_range(7, 127))
					: dils_pkg::CountW'($urandom_range(0, 6));
				queue_byte({1'b0, cnt});
				repeat (cnt)
					queue_byte(dils_pkg::ByteW'($urandom_range(0, 255)));
			end
		end
	endtask

	// all bytes taken and all requests seen, then time for bytes that cause
	// no request to settle in the block
	task automatic wait_idle();
		do
			@(negedge clk);
		while (accepted_cnt != pushed_cnt || req_expected.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_delay_unit(input logic [dils_pkg::ByteW-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		unit_ms = v;
	endtask

	// input driver: holds a byte until its transfer, then waits out a gap
	always @(negedge clk) begin
		if (arst_n) begin
			if (!(list_if.valid && !byte_taken)) begin
				if (byte_taken) begin
					byte_taken = 0;
					send_gap = pick_gap();
				end
				if (send_gap > 0) begin
					list_if.valid <= 1'b0;
					send_gap--;
				end else if (list_q.size() > 0) begin
					list_if.valid     <= 1'b1;
					list_if.list_byte <= list_q.pop_front();
				end else begin
					list_if.valid <= 1'b0;
				end
			end
		end
	end

	// input transfer: advance the shadow walker
	always @(posedge clk) begin
		if (arst_n && list_if.valid && list_if.ready) begin
			byte_taken = 1;
			accepted_cnt++;
			walk_list_byte(list_if.list_byte);
		end
	end

	// receiver: random stalls, plus a long counted hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HoldCycles;
			hold_req  = 0;
		end
		if (!arst_n) begin
			req_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			req_if.ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			req_if.ready <= 1'b0;
			stall_left--;
		end else begin
			req_if.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	// output monitor: each transfer against the oldest prediction
	always @(posedge clk) begin
		req_t want;
		if (arst_n && req_if.valid && req_if.ready) begin
			if (req_expected.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected request: kind %0d byte %0h delay %0d",
						req_if.kind, req_if.byte_value, req_if.delay_ms);
			end else begin
				want = req_expected.pop_front();
				if (req_if.kind !== want.kind || req_if.byte_value !== want.byte_value
						|| req_if.delay_ms !== want.delay_ms) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("request differs: want kind %0d byte %0h delay %0d,",
							want.kind, want.byte_value, want.delay_ms,
							" got kind %0d byte %0h delay %0d",
							req_if.kind, req_if.byte_value, req_if.delay_ms);
				end
			end
		end
	end

	initial begin
		logic [dils_pkg::ByteW-1:0] units[5];
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		list_if.valid     = 1'b0;
		list_if.list_byte = '0;
		req_if.ready      = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: zero data count, data extremes, delay-only entries,
		// zero count delay, full count delay, command followed by delay
		queue_byte(8'h01); queue_byte(8'h00);
		queue_byte(8'hFE); queue_byte(8'h02); queue_byte(8'h00); queue_byte(8'hFF);
		queue_byte(dils_pkg::NoCmdMark); queue_byte(8'h80);
		queue_byte(dils_pkg::NoCmdMark); queue_byte(8'hFF);
		queue_byte(8'h2A); queue_byte(8'h81);
		queue_byte(8'h7F); queue_byte(8'h01); queue_byte(8'hA5);
		wait_idle();
		// largest unit with largest count
		set_delay_unit(8'd255);
		queue_byte(dils_pkg::NoCmdMark); queue_byte(8'hFF);
		queue_byte(8'h80); queue_byte(8'h83);
		wait_idle();
		// unit of zero gives zero length delays
		set_delay_unit(8'd0);
		queue_byte(dils_pkg::NoCmdMark); queue_byte(8'h85);
		wait_idle();
		set_delay_unit(8'd1);
		queue_byte(dils_pkg::NoCmdMark); queue_byte(8'hC0);
		wait_idle();

		// random phases, each behind its own delay unit setting
		units[0] = 8'd255;
		units[1] = 8'd1;
		units[2] = dils_pkg::ByteW'($urandom_range(2, 254));
		units[3] = 8'd0;
		units[4] = dils_pkg::ByteW'($urandom_range(1, 255));
		for (int p = 0; p < 5; p++) begin
			int unsigned target;
			set_delay_unit(units[p]);
			// phase 1 starts with the receiver held off so the block backs up
			if (p == 1)
				hold_req = 1;
			// phase 3 runs with no idling on either side
			no_idle = (p == 3);
			target = pushed_cnt + 300;
			while (pushed_cnt < target)
				queue_entry();
			wait_idle();
		end
		no_idle = 0;

		// close the list, then bytes that must all be dropped
		while (plan_phase != dils_pkg::PH_CMD)
			queue_noise();
		queue_byte(dils_pkg::EndMark);
		repeat (20)
			queue_byte(dils_pkg::ByteW'($urandom_range(0, 255)));
		queue_byte(8'h00);
		wait_idle();
		repeat (8) @(negedge clk);

		if (mismatch_cnt == 0 && req_expected.size() == 0)
			$display("display_init_list_sequencer: match");
		else
			$display("display_init_list_sequencer: mismatch");
		$finish;
	end

	// run limit
	initial begin
		#6000000;
		$display("display_init_list_sequencer: mismatch");
		$finish;
	end

endmodule
